>>> hdl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg: shared types and constants of the chunked body decoder
// Parse phases, status codes, character codes and the result word layout.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // Parse phase, one-hot
    typedef enum logic [9:0] {
        PH_LEAD    = 10'b00_0000_0001,
        PH_DIGITS  = 10'b00_0000_0010,
        PH_TEXT    = 10'b00_0000_0100,
        PH_SIZE_LF = 10'b00_0000_1000,
        PH_DATA    = 10'b00_0001_0000,
        PH_DATA_CR = 10'b00_0010_0000,
        PH_DATA_LF = 10'b00_0100_0000,
        PH_END_CR  = 10'b00_1000_0000,
        PH_END_LF  = 10'b01_0000_0000,
        PH_HALT    = 10'b10_0000_0000
    } t_phase;

    // Body status codes
    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Result word handed from the parser to the output register
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] status;
    } t_result;

    // Hex digit decode
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

>>> hdl/hcd_in_if.sv
// ----------------------------------------------------------------------------
// hcd_in_if: raw body byte channel
// Valid/ready channel carrying one body byte and its last flag per word.
// ----------------------------------------------------------------------------
interface hcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

>>> hdl/hcd_out_if.sv
// ----------------------------------------------------------------------------
// hcd_out_if: decoded result channel
// Valid/ready channel carrying one decoded result word per input byte.
// ----------------------------------------------------------------------------
interface hcd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] status;

    modport source (output valid, output data_valid, output data_byte, output status,
                    input ready);
    modport sink   (input valid, input data_valid, input data_byte, input status,
                    output ready);
endinterface

>>> hdl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: chunked transfer body decoder
// Parses a chunked body one byte per word and emits one result per byte.
// ----------------------------------------------------------------------------
// Each accepted byte's result word is registered and appears on o_out in the cycle after.
// Throughput: 1 byte per cycle; the output register refills in the cycle
//   it is drained, so the input stalls only while o_out is held off.
// Reset: synchronous active-low i_rst_n clears the parse state to the
//   start of a size line and empties the output register.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcd_in_if.sink    i_in,
    hcd_out_if.source o_out
);

    logic             r_out_valid;
    hcd_pkg::t_result r_result;
    hcd_pkg::t_result w_result;
    logic             w_accept;

    // Take a byte whenever the output register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    hcd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.byte_in),
        .i_last   (i_in.last),
        .o_result (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data_valid = r_result.data_valid;
    assign o_out.data_byte  = r_result.data_byte;
    assign o_out.status     = r_result.status;

endmodule

>>> hdl/hcd_parser.sv
// ----------------------------------------------------------------------------
// hcd_parser: chunked framing state machine
// Holds the parse state and computes one result word per accepted byte.
// ----------------------------------------------------------------------------
module hcd_parser #(
    parameter int SIZE_BITS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output hcd_pkg::t_result   o_result
);

    hcd_pkg::t_phase   r_phase,      n_phase;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic              r_digit_seen, n_digit_seen;
    hcd_pkg::t_status  r_outcome,    n_outcome;

    hcd_pkg::t_hex     w_hex;
    logic              w_ovf;

    assign w_hex = hcd_pkg::hex_decode(i_byte);
    // next digit would push the size past SIZE_BITS
    assign w_ovf = (r_bytes_left[SIZE_BITS-1 -: 4] != 4'd0);

    // Next state and result for the byte on the input
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_digit_seen = r_digit_seen;
        n_outcome    = r_outcome;
        o_result.data_valid = 1'b0;
        o_result.data_byte  = 8'd0;

        unique case (r_phase)
            hcd_pkg::PH_LEAD: begin
                if (i_byte == hcd_pkg::CH_SPACE || i_byte == hcd_pkg::CH_TAB) begin
                    n_phase = r_phase;
                end else if (!w_hex.ok) begin
                    n_outcome = hcd_pkg::ST_ERR;
                    n_phase   = hcd_pkg::PH_HALT;
                end else begin
                    n_bytes_left = SIZE_BITS'(w_hex.val);
                    n_digit_seen = 1'b1;
                    n_phase      = hcd_pkg::PH_DIGITS;
                end
            end
            hcd_pkg::PH_DIGITS: begin
                if (w_hex.ok) begin
                    if (w_ovf) begin
                        n_outcome = hcd_pkg::ST_ERR;
                        n_phase   = hcd_pkg::PH_HALT;
                    end else begin
                        n_bytes_left = {r_bytes_left[SIZE_BITS-5:0], w_hex.val};
                    end
                end else if (i_byte == hcd_pkg::CH_CR) begin
                    n_phase = hcd_pkg::PH_SIZE_LF;
                end else begin
                    n_phase = hcd_pkg::PH_TEXT;
                end
            end
            hcd_pkg::PH_TEXT: begin
                if (i_byte == hcd_pkg::CH_CR) begin
                    n_phase = hcd_pkg::PH_SIZE_LF;
                end
            end
            hcd_pkg::PH_SIZE_LF: begin
                if (i_byte == hcd_pkg::CH_LF) begin
                    if (!r_digit_seen) begin
                        n_outcome = hcd_pkg::ST_ERR;
                        n_phase   = hcd_pkg::PH_HALT;
                    end else begin
                        n_digit_seen = 1'b0;
                        n_phase = (r_bytes_left == '0) ? hcd_pkg::PH_END_CR
                                                       : hcd_pkg::PH_DATA;
                    end
                end else if (i_byte != hcd_pkg::CH_CR) begin
                    n_phase = hcd_pkg::PH_TEXT;
                end
            end
            hcd_pkg::PH_DATA: begin
                o_result.data_valid = 1'b1;
                o_result.data_byte  = i_byte;
                n_bytes_left = r_bytes_left - SIZE_BITS'(1);
                if (r_bytes_left == SIZE_BITS'(1)) begin
                    n_phase = hcd_pkg::PH_DATA_CR;
                end
            end
            hcd_pkg::PH_DATA_CR: begin
                if (i_byte == hcd_pkg::CH_CR) begin
                    n_phase = hcd_pkg::PH_DATA_LF;
                end else begin
                    n_outcome = hcd_pkg::ST_ERR;
                    n_phase   = hcd_pkg::PH_HALT;
                end
            end
            hcd_pkg::PH_DATA_LF: begin
                if (i_byte == hcd_pkg::CH_LF) begin
                    n_phase      = hcd_pkg::PH_LEAD;
                    n_bytes_left = '0;
                    n_digit_seen = 1'b0;
                end else begin
                    n_outcome = hcd_pkg::ST_ERR;
                    n_phase   = hcd_pkg::PH_HALT;
                end
            end
            hcd_pkg::PH_END_CR: begin
                if (i_byte == hcd_pkg::CH_CR) begin
                    n_phase = hcd_pkg::PH_END_LF;
                end else begin
                    n_outcome = hcd_pkg::ST_ERR;
                    n_phase   = hcd_pkg::PH_HALT;
                end
            end
            hcd_pkg::PH_END_LF: begin
                if (i_byte == hcd_pkg::CH_LF) begin
                    n_outcome = hcd_pkg::ST_DONE;
                end else begin
                    n_outcome = hcd_pkg::ST_ERR;
                end
                n_phase = hcd_pkg::PH_HALT;
            end
            default: begin
                n_phase = hcd_pkg::PH_HALT;
            end
        endcase

        // body cut short by the last byte
        if (i_last && n_outcome == hcd_pkg::ST_BUSY) begin
            n_outcome = hcd_pkg::ST_ERR;
            n_phase   = hcd_pkg::PH_HALT;
        end
        o_result.status = n_outcome;

        // last byte: start over for the next body
        if (i_last) begin
            n_phase      = hcd_pkg::PH_LEAD;
            n_bytes_left = '0;
            n_digit_seen = 1'b0;
            n_outcome    = hcd_pkg::ST_BUSY;
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hcd_pkg::PH_LEAD;
            r_bytes_left <= '0;
            r_digit_seen <= 1'b0;
            r_outcome    <= hcd_pkg::ST_BUSY;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_digit_seen <= n_digit_seen;
            r_outcome    <= n_outcome;
        end
    end

endmodule
